// ===== hdl/wre_pkg.sv =====
// shared types, codes and helpers for the watchdog recovery escalation block
package wre_pkg;

    localparam int OP_W      = 3;
    localparam int OUTCOME_W = 2;
    localparam int COUNT_W   = 8;
    localparam int MS_W      = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;

    typedef enum logic [1:0] {
        ST_RUNNING       = 2'd0,
        ST_IN_RESET      = 2'd1,
        ST_EXIT_RESET    = 2'd2,
        ST_ROLLBACK_DONE = 2'd3
    } fsm_state_t;

    typedef enum logic [1:0] {
        IRQ_NONE    = 2'd0,
        IRQ_DISABLE = 2'd1,
        IRQ_ENABLE  = 2'd2
    } irq_action_t;

    typedef enum logic [OP_W-1:0] {
        OP_RESET_ASSERT  = 3'd0,
        OP_RESET_RELEASE = 3'd1,
        OP_CS_FIRST      = 3'd2,
        OP_CS_SECOND     = 3'd3,
        OP_START_IN_RST  = 3'd4,
        OP_MS_TICK       = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_RW       = 2'd1,
        ERR_ROLLBACK = 2'd2,
        ERR_IMAGE    = 2'd3
    } err_src_t;

    localparam logic [OUTCOME_W-1:0] OUTCOME_OK   = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUTCOME_SOFT = 2'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MS = 2'd1;

    typedef struct packed {
        logic [OUTCOME_W-1:0] image_outcome;
        logic [OUTCOME_W-1:0] rollback_outcome;
        logic [OUTCOME_W-1:0] rw_outcome;
        logic [OP_W-1:0]      operation;
    } in_beat_t;

    typedef struct packed {
        err_src_t           error_source;
        logic               skip_flag;
        logic [COUNT_W-1:0] watchdog_count;
        logic               reset_pulse;
        logic               ran_image_apply;
        logic               ran_rollback;
        logic               ran_rw_recovery;
        irq_action_t        cs_irq_action;
        fsm_state_t         fsm_state;
    } out_beat_t;

    typedef struct packed {
        fsm_state_t         fsm;
        logic [COUNT_W-1:0] count;
        logic               skip;
        logic [MS_W-1:0]    ms;
    } wre_state_t;

    typedef struct packed {
        logic [COUNT_W-1:0] min_count;
        logic [MS_W-1:0]    timeout_ms;
    } wre_cfg_t;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        sat_inc = (v == {COUNT_W{1'b1}}) ? v : v + COUNT_W'(1);
    endfunction

endpackage

// ===== hdl/wre_step.sv =====
// next-state and result logic for one host event
module wre_step import wre_pkg::*; (
    input  wre_state_t cur,
    input  wre_cfg_t   cfg,
    input  in_beat_t   beat,
    output wre_state_t nxt,
    output out_beat_t  res
);

    logic [COUNT_W-1:0]   cnt;
    logic                 skip;
    logic [OUTCOME_W-1:0] last_outcome;
    logic [COUNT_W:0]     min_p1;
    logic [COUNT_W:0]     min_p2;

    assign min_p1 = {1'b0, cfg.min_count} + (COUNT_W+1)'(1);
    assign min_p2 = {1'b0, cfg.min_count} + (COUNT_W+1)'(2);

    always_comb begin
        nxt          = cur;
        res          = '0;
        cnt          = cur.count;
        skip         = cur.skip;
        last_outcome = OUTCOME_OK;
        unique case (op_t'(beat.operation))
            OP_RESET_ASSERT: begin
                if (cur.fsm == ST_RUNNING || cur.fsm == ST_EXIT_RESET) begin
                    res.cs_irq_action = IRQ_ENABLE;
                    nxt.fsm           = ST_IN_RESET;
                end
            end
            OP_RESET_RELEASE: begin
                if (cur.fsm == ST_IN_RESET || cur.fsm == ST_ROLLBACK_DONE) begin
                    nxt.fsm = ST_EXIT_RESET;
                end
            end
            OP_CS_FIRST: begin
                if (cur.fsm == ST_RUNNING || cur.fsm == ST_EXIT_RESET) begin
                    res.cs_irq_action = IRQ_DISABLE;
                    nxt.fsm           = ST_RUNNING;
                end else if (cur.fsm == ST_ROLLBACK_DONE) begin
                    nxt.fsm = ST_IN_RESET;
                end
            end
            OP_CS_SECOND: begin
                if (cur.fsm == ST_RUNNING) begin
                    res.cs_irq_action = IRQ_DISABLE;
                end else if (cur.fsm == ST_IN_RESET || cur.fsm == ST_EXIT_RESET) begin
                    // timer expired: forget earlier watchdog resets
                    if (cur.ms == '0) begin
                        cnt  = '0;
                        skip = 1'b0;
                    end
                    if (cnt < cfg.min_count) begin
                        res.reset_pulse = 1'b1;
                    end else begin
                        if (cnt == cfg.min_count) begin
                            res.ran_rw_recovery = 1'b1;
                            last_outcome        = beat.rw_outcome;
                            res.error_source    = ERR_RW;
                            if (beat.rw_outcome == OUTCOME_SOFT) begin
                                cnt = sat_inc(cnt);
                            end
                        end
                        // later steps see the count as bumped by earlier ones
                        if (skip || {1'b0, cnt} == min_p1) begin
                            res.ran_rollback = 1'b1;
                            last_outcome     = beat.rollback_outcome;
                            res.error_source = ERR_ROLLBACK;
                            if (beat.rollback_outcome == OUTCOME_SOFT) begin
                                cnt = sat_inc(cnt);
                            end
                        end
                        if (!skip && {1'b0, cnt} >= min_p2) begin
                            res.ran_image_apply = 1'b1;
                            last_outcome        = beat.image_outcome;
                            res.error_source    = ERR_IMAGE;
                            if (beat.image_outcome == OUTCOME_SOFT) begin
                                skip = 1'b1;
                            end
                        end
                        if (last_outcome != OUTCOME_OK) begin
                            res.reset_pulse = 1'b1;
                        end else begin
                            res.error_source = ERR_NONE;
                        end
                    end
                    nxt.fsm   = ST_ROLLBACK_DONE;
                    nxt.count = sat_inc(cnt);
                    nxt.skip  = skip;
                    nxt.ms    = cfg.timeout_ms;
                end
            end
            OP_START_IN_RST: begin
                res.cs_irq_action = IRQ_ENABLE;
                nxt.fsm           = ST_IN_RESET;
            end
            OP_MS_TICK: begin
                if (cur.ms != '0) begin
                    nxt.ms = cur.ms - MS_W'(1);
                end
            end
            default: begin
            end
        endcase
        res.fsm_state      = nxt.fsm;
        res.watchdog_count = nxt.count;
        res.skip_flag      = nxt.skip;
    end

endmodule

// ===== hdl/watchdog_recovery_escalation_fsm_top.sv =====
// top level of the watchdog recovery escalation block
// Takes one host event per input beat and returns exactly one result beat for it. The
// event is decoded and applied to the recovery state in the same cycle it is accepted, and
// the result lands in an output register in the next cycle; a new event is accepted every
// cycle while the output register is empty or being drained, so the sustained rate is one
// beat per clock. The operation outcomes for read-write
// recovery, flash rollback and image apply travel with each event. Configuration writes
// (index 0: minimum watchdog count, index 1: timeout in ms) are always ready and should
// only be issued while no result is pending.
module watchdog_recovery_escalation_fsm_top import wre_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [2:0] operation, [4:3] rw_outcome, [6:5] rollback_outcome, [8:7] image_outcome
    input  logic [S_TDATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [1:0] fsm_state, [3:2] cs_irq_action, [4] ran_rw_recovery, [5] ran_rollback,
    // [6] ran_image_apply, [7] reset_pulse, [15:8] watchdog_count, [16] skip_flag,
    // [18:17] error_source
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    wre_state_t state_reg;
    wre_state_t state_next;
    wre_cfg_t   cfg_reg;
    out_beat_t  res_next;
    out_beat_t  res_reg;
    logic       m_valid_reg;
    logic       in_fire;

    assign s_tready  = !m_valid_reg || m_tready;
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    wre_step u_step (
        .cur  (state_reg),
        .cfg  (cfg_reg),
        .beat (in_beat_t'(s_tdata[$bits(in_beat_t)-1:0])),
        .nxt  (state_next),
        .res  (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= '{fsm: ST_RUNNING, count: '0, skip: 1'b0, ms: '0};
            cfg_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (in_fire) begin
                state_reg <= state_next;
            end
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_MIN_COUNT:  cfg_reg.min_count  <= cfg_data[COUNT_W-1:0];
                    CFG_TIMEOUT_MS: cfg_reg.timeout_ms <= cfg_data[MS_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (in_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(M_TDATA_W-$bits(out_beat_t))'(0), res_reg};

endmodule

// ===== hdl/wre_checker.sv =====
// port-level checks for the watchdog recovery escalation block, bound to the top level
module wre_checker import wre_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // a stalled result beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // input side never waits on an empty output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // any recovery operation only happens on entry to rollback done
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[6:4] != 3'b000) |-> m_tdata[1:0] == ST_ROLLBACK_DONE)
        else $error("recovery operation outside rollback done");

    // a reported error source always comes with a reset pulse
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[18:17] != ERR_NONE) |-> m_tdata[7])
        else $error("error source without reset pulse");

    // irq enable only when entering in reset
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[3:2] == IRQ_ENABLE) |-> m_tdata[1:0] == ST_IN_RESET)
        else $error("irq enable outside in reset");

endmodule

bind watchdog_recovery_escalation_fsm_top wre_checker u_wre_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== test/watchdog_recovery_escalation_fsm_top_tb.sv =====
// self-checking testbench for the watchdog recovery escalation block
`timescale 1ns / 100ps

module watchdog_recovery_escalation_fsm_top_tb;
    import wre_pkg::*;

    localparam logic [OP_W-1:0]      OP_SPARE_A       = 3'd6;
    localparam logic [OP_W-1:0]      OP_SPARE_B       = 3'd7;
    localparam logic [OUTCOME_W-1:0] OUTCOME_FAIL     = 2'd2;
    localparam logic [OUTCOME_W-1:0] OUTCOME_FAIL_ALT = 2'd3;
    localparam int LONG_HOLD   = 300;
    localparam int STALL_LIMIT = 2000;

    typedef enum {READY_RUN, STALL_RUN, COIN_FLIP, TOGGLE} sink_mode_t;

    // tracks the recovery state machine and holds the result beats still owed by the block
    class recovery_checker;
        fsm_state_t         fsm;
        logic [COUNT_W-1:0] resets_seen;
        logic               image_skipped;
        logic [MS_W-1:0]    quiet_ms_left;
        logic [COUNT_W-1:0] min_count;
        logic [MS_W-1:0]    timeout_ms;
        out_beat_t          awaited[$];
        int                 errors;

        function new();
            fsm           = ST_RUNNING;
            resets_seen   = '0;
            image_skipped = 1'b0;
            quiet_ms_left = '0;
            min_count     = '0;
            timeout_ms    = '0;
            errors        = 0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_MIN_COUNT: min_count = data[COUNT_W-1:0];
                CFG_TIMEOUT_MS: timeout_ms = data[MS_W-1:0];
                default: ;
            endcase
        endfunction

        function void bump_resets();
            if (resets_seen != {COUNT_W{1'b1}})
                resets_seen = resets_seen + 1'b1;
        endfunction

        function void note_event(in_beat_t ev);
            out_beat_t            r;
            logic [OUTCOME_W-1:0] last;
            r = '0;
            r.cs_irq_action = IRQ_NONE;
            r.error_source  = ERR_NONE;
            last = OUTCOME_OK;
            case (ev.operation)
                OP_RESET_ASSERT: begin
                    if (fsm == ST_RUNNING || fsm == ST_EXIT_RESET) begin
                        r.cs_irq_action = IRQ_ENABLE;
                        fsm = ST_IN_RESET;
                    end
                end
                OP_RESET_RELEASE: begin
                    if (fsm == ST_IN_RESET || fsm == ST_ROLLBACK_DONE)
                        fsm = ST_EXIT_RESET;
                end
                OP_CS_FIRST: begin
                    if (fsm == ST_RUNNING || fsm == ST_EXIT_RESET) begin
                        r.cs_irq_action = IRQ_DISABLE;
                        fsm = ST_RUNNING;
                    end else if (fsm == ST_ROLLBACK_DONE) begin
                        fsm = ST_IN_RESET;
                    end
                end
                OP_CS_SECOND: begin
                    if (fsm == ST_RUNNING) begin
                        r.cs_irq_action = IRQ_DISABLE;
                    end else if (fsm != ST_ROLLBACK_DONE) begin
                        // quiet period over: forget earlier watchdog resets
                        if (quiet_ms_left == '0) begin
                            resets_seen   = '0;
                            image_skipped = 1'b0;
                        end
                        if (resets_seen < min_count) begin
                            r.reset_pulse = 1'b1;
                        end else begin
                            // each step sees the count left by the one before it
                            if (resets_seen == min_count) begin
                                r.ran_rw_recovery = 1'b1;
                                r.error_source = ERR_RW;
                                last = ev.rw_outcome;
                                if (ev.rw_outcome == OUTCOME_SOFT)
                                    bump_resets();
                            end
                            if (image_skipped || int'(resets_seen) == int'(min_count) + 1) begin
                                r.ran_rollback = 1'b1;
                                r.error_source = ERR_ROLLBACK;
                                last = ev.rollback_outcome;
                                if (ev.rollback_outcome == OUTCOME_SOFT)
                                    bump_resets();
                            end
                            if (!image_skipped && int'(resets_seen) >= int'(min_count) + 2) begin
                                r.ran_image_apply = 1'b1;
                                r.error_source = ERR_IMAGE;
                                last = ev.image_outcome;
                                if (ev.image_outcome == OUTCOME_SOFT)
                                    image_skipped = 1'b1;
                            end
                            if (last != OUTCOME_OK)
                                r.reset_pulse = 1'b1;
                            else
                                r.error_source = ERR_NONE;
                        end
                        fsm = ST_ROLLBACK_DONE;
                        bump_resets();
                        quiet_ms_left = timeout_ms;
                    end
                end
                OP_START_IN_RST: begin
                    r.cs_irq_action = IRQ_ENABLE;
                    fsm = ST_IN_RESET;
                end
                OP_MS_TICK: begin
                    if (quiet_ms_left != '0)
                        quiet_ms_left = quiet_ms_left - 1'b1;
                end
                default: ;
            endcase
            r.fsm_state      = fsm;
            r.watchdog_count = resets_seen;
            r.skip_flag      = image_skipped;
            awaited.push_back(r);
        endfunction

        function void compare(string field, int want, int got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] beat);
            out_beat_t got;
            out_beat_t want;
            if (awaited.size() == 0) begin
                $error("result beat %h arrived with nothing outstanding", beat);
                errors++;
                return;
            end
            want = awaited.pop_front();
            got  = out_beat_t'(beat[$bits(out_beat_t)-1:0]);
            compare("fsm_state", int'(want.fsm_state), int'(got.fsm_state));
            compare("cs_irq_action", int'(want.cs_irq_action), int'(got.cs_irq_action));
            compare("ran_rw_recovery", int'(want.ran_rw_recovery), int'(got.ran_rw_recovery));
            compare("ran_rollback", int'(want.ran_rollback), int'(got.ran_rollback));
            compare("ran_image_apply", int'(want.ran_image_apply), int'(got.ran_image_apply));
            compare("reset_pulse", int'(want.reset_pulse), int'(got.reset_pulse));
            compare("watchdog_count", int'(want.watchdog_count), int'(got.watchdog_count));
            compare("skip_flag", int'(want.skip_flag), int'(got.skip_flag));
            compare("error_source", int'(want.error_source), int'(got.error_source));
            compare("padding", 0, int'(beat[M_TDATA_W-1:$bits(out_beat_t)]));
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    recovery_checker tracker = new();
    int  items_sent;
    int  burst_left;
    int  idle_cycles = 0;
    bit  hold_off_req = 1'b0;

    watchdog_recovery_escalation_fsm_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            tracker.note_event(in_beat_t'(s_tdata[$bits(in_beat_t)-1:0]));
        if (aresetn && m_tvalid && m_tready)
            tracker.check_result(m_tdata);
        if (aresetn && cfg_valid && cfg_ready)
            tracker.write_reg(cfg_index, cfg_data);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : result_sink
        sink_mode_t mode;
        int         run;
        int         i;
        m_tready <= 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_off_req) begin
                // long back-pressure so the block fills up and stalls its input
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end
            mode = sink_mode_t'($urandom_range(0, 3));
            run  = (mode == READY_RUN) ? $urandom_range(1, 60) : $urandom_range(1, 16);
            for (i = 0; i < run; i++) begin
                case (mode)
                    READY_RUN: m_tready <= 1'b1;
                    STALL_RUN: m_tready <= 1'b0;
                    COIN_FLIP: m_tready <= 1'($urandom_range(0, 1));
                    default:   m_tready <= i[0];
                endcase
                @(posedge aclk);
            end
        end
    end

    function automatic in_beat_t make_event(logic [OP_W-1:0] op, logic [OUTCOME_W-1:0] rw,
                                            logic [OUTCOME_W-1:0] rb,
                                            logic [OUTCOME_W-1:0] im);
        in_beat_t ev;
        ev.operation        = op;
        ev.rw_outcome       = rw;
        ev.rollback_outcome = rb;
        ev.image_outcome    = im;
        return ev;
    endfunction

    function automatic in_beat_t random_outcomes(logic [OP_W-1:0] op);
        return make_event(op, OUTCOME_W'($urandom_range(0, 3)), OUTCOME_W'($urandom_range(0, 3)),
                          OUTCOME_W'($urandom_range(0, 3)));
    endfunction

    task automatic send_event(input in_beat_t ev);
        int gap;
        s_tdata  <= {{(S_TDATA_W - $bits(in_beat_t)){1'b0}}, ev};
        s_tvalid <= 1'b1;
        @(posedge aclk iff s_tready);
        items_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 16);
            gap = $urandom_range(1, 8);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        // let the monitor log the last accepted beat before counting
        @(posedge aclk);
        while (tracker.pending() != 0)
            @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        drain_results();
        repeat (4) @(posedge aclk);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk iff cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_noise(input int tick_pct);
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (pick < tick_pct) begin
            n = $urandom_range(1, 6);
            repeat (n) send_event(random_outcomes(OP_MS_TICK));
        end else if (pick < tick_pct + 8) begin
            send_event(random_outcomes(($urandom_range(0, 1) != 0) ? OP_SPARE_A : OP_SPARE_B));
        end else begin
            send_event(random_outcomes(OP_W'($urandom_range(OP_RESET_ASSERT, OP_START_IN_RST))));
        end
    endtask

    // mostly watchdog retry loops (release then second chip select), the rest random events
    task automatic random_phase(input int n_items, input int retry_pct, input int tick_pct);
        int target;
        target = items_sent + n_items;
        while (items_sent < target) begin
            if ($urandom_range(0, 99) < retry_pct) begin
                send_event(random_outcomes(OP_RESET_RELEASE));
                send_event(random_outcomes(OP_CS_SECOND));
            end else begin
                send_noise(tick_pct);
            end
        end
    endtask

    initial begin : stimulus
        aresetn    <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        cfg_valid  <= 1'b0;
        cfg_index  <= CFG_MIN_COUNT;
        cfg_data   <= '0;
        items_sent = 0;
        burst_left = 1;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset configuration: minimum 0, timer always expired
        send_event(make_event(OP_SPARE_A, OUTCOME_FAIL_ALT, OUTCOME_FAIL_ALT, OUTCOME_FAIL_ALT));
        send_event(make_event(OP_SPARE_B, OUTCOME_OK, OUTCOME_OK, OUTCOME_OK));
        send_event(make_event(OP_CS_FIRST, OUTCOME_OK, OUTCOME_OK, OUTCOME_OK));
        send_event(make_event(OP_CS_SECOND, OUTCOME_SOFT, OUTCOME_SOFT, OUTCOME_SOFT));
        send_event(make_event(OP_MS_TICK, OUTCOME_OK, OUTCOME_OK, OUTCOME_OK));
        send_event(make_event(OP_RESET_RELEASE, OUTCOME_OK, OUTCOME_OK, OUTCOME_OK));
        send_event(make_event(OP_RESET_ASSERT, OUTCOME_OK, OUTCOME_OK, OUTCOME_OK));
        send_event(make_event(OP_RESET_ASSERT, OUTCOME_OK, OUTCOME_OK, OUTCOME_OK));
        send_event(make_event(OP_CS_FIRST, OUTCOME_OK, OUTCOME_OK, OUTCOME_OK));
        send_event(make_event(OP_CS_SECOND, OUTCOME_FAIL_ALT, OUTCOME_OK, OUTCOME_OK));
        send_event(make_event(OP_RESET_ASSERT, OUTCOME_OK, OUTCOME_OK, OUTCOME_OK));
        send_event(make_event(OP_CS_FIRST, OUTCOME_OK, OUTCOME_OK, OUTCOME_OK));
        send_event(make_event(OP_RESET_RELEASE, OUTCOME_OK, OUTCOME_OK, OUTCOME_OK));
        send_event(make_event(OP_CS_SECOND, OUTCOME_SOFT, OUTCOME_OK, OUTCOME_OK));
        send_event(make_event(OP_RESET_RELEASE, OUTCOME_OK, OUTCOME_OK, OUTCOME_OK));
        send_event(make_event(OP_CS_SECOND, OUTCOME_FAIL, OUTCOME_FAIL, OUTCOME_FAIL));

        // live timer: walk through rollback, image apply and the skip path
        write_reg(CFG_TIMEOUT_MS, 16'd1000);
        send_event(make_event(OP_START_IN_RST, OUTCOME_OK, OUTCOME_OK, OUTCOME_OK));
        send_event(make_event(OP_CS_SECOND, OUTCOME_OK, OUTCOME_OK, OUTCOME_OK));
        send_event(make_event(OP_RESET_RELEASE, OUTCOME_OK, OUTCOME_OK, OUTCOME_OK));
        send_event(make_event(OP_CS_SECOND, OUTCOME_OK, OUTCOME_SOFT, OUTCOME_SOFT));
        send_event(make_event(OP_RESET_RELEASE, OUTCOME_OK, OUTCOME_OK, OUTCOME_OK));
        send_event(make_event(OP_CS_SECOND, OUTCOME_FAIL, OUTCOME_FAIL_ALT, OUTCOME_FAIL));
        send_event(make_event(OP_MS_TICK, OUTCOME_OK, OUTCOME_OK, OUTCOME_OK));
        send_event(make_event(OP_MS_TICK, OUTCOME_OK, OUTCOME_OK, OUTCOME_OK));
        send_event(make_event(OP_START_IN_RST, OUTCOME_OK, OUTCOME_OK, OUTCOME_OK));
        send_event(make_event(OP_CS_SECOND, OUTCOME_OK, OUTCOME_OK, OUTCOME_OK));

        // short timeout, lots of ticks so the count keeps expiring
        write_reg(CFG_MIN_COUNT, 16'd3);
        write_reg(CFG_TIMEOUT_MS, 16'd4);
        random_phase(200, 60, 40);
        hold_off_req = 1'b1;
        random_phase(200, 60, 40);

        // highest minimum in this test, with the timer always expired: pulses only
        write_reg(CFG_MIN_COUNT, 16'd250);
        write_reg(CFG_TIMEOUT_MS, 16'd0);
        random_phase(100, 60, 10);

        // longest timeout: climb past the minimum and into saturation
        write_reg(CFG_TIMEOUT_MS, 16'hFFFF);
        random_phase(450, 80, 5);
        drain_results();
        random_phase(450, 80, 5);

        write_reg(CFG_MIN_COUNT, 16'd1);
        write_reg(CFG_TIMEOUT_MS, 16'd2);
        random_phase(300, 55, 40);

        write_reg(CFG_MIN_COUNT, 16'd0);
        write_reg(CFG_TIMEOUT_MS, 16'd0);
        random_phase(225, 60, 20);

        drain_results();
        repeat (8) @(posedge aclk);
        if (tracker.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/wre_pkg.sv
hdl/wre_step.sv
hdl/watchdog_recovery_escalation_fsm_top.sv
hdl/wre_checker.sv
test/watchdog_recovery_escalation_fsm_top_tb.sv
